// ----- hw/rtl/hysteresis_turning_point_finder_macros.svh -----
// Assertion macros for the hysteresis turning-point finder.
// Included by the top level; no other dependencies.
`ifndef HYSTERESIS_TURNING_POINT_FINDER_MACROS_SVH
`define HYSTERESIS_TURNING_POINT_FINDER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HTPF_ASSERT_SAME(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("htpf check failed");
`define HTPF_ASSERT_NEXT(label, clk, rst_n, ant, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("htpf check failed");
`else
`define HTPF_ASSERT_SAME(label, clk, rst_n, ant, cons)
`define HTPF_ASSERT_NEXT(label, clk, rst_n, ant, cons)
`endif
`endif

// ----- hw/rtl/htpf_pkg.sv -----
// Shared constants and types for the hysteresis turning-point finder.
// No dependencies.
package htpf_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_TIME_WIDTH  = 48;

    localparam int          AMP_WIDTH = 31;
    localparam logic [30:0] AMP_RESET = 31'd65536;

    // result queue depth; one item can push two results
    localparam int RQ_DEPTH = 4;

    // register indexes on the config port
    localparam logic REG_MIN_AMPLITUDE = 1'b0;

    typedef struct packed {
        logic status;
        logic curve_end;
        logic run_end;
    } t_flags;

endpackage

// ----- hw/rtl/hysteresis_turning_point_finder.sv -----
// Hysteresis turning-point finder (zigzag peak detection) top level.
// Depends on htpf_pkg and hysteresis_turning_point_finder_macros.svh.
//
// Usage:
//   Samples of one curve enter on the s_ stream: tdata holds time and value,
//   tuser marks the first sample of a curve, tlast the final one. Results leave
//   on the m_ stream: tdata holds the point's time and value, tlast marks the
//   final result of a curve, tuser holds run_end (bit 0) and status (bit 1).
//   min_amplitude is written over the APB port at address 0 while idle.
// Timing:
//   Each accepted item is evaluated in the cycle it is taken and its results
//   are written to a four-entry result queue; the first result is visible on
//   the next cycle. One item can be taken every cycle while s_tready is high;
//   items give zero, one or two results, drained one per cycle while m_tready
//   is high. s_tready stays high while the queue has room for two more
//   results, so when results pile up the input stalls until the queue drains.
// Reset:
//   Synchronous, active low. The curve state returns to idle, the queue is
//   emptied and min_amplitude returns to 65536. A stalled receiver only holds
//   results in the queue; nothing is dropped.
module hysteresis_turning_point_finder #(
    parameter int VALUE_WIDTH = htpf_pkg::DEF_VALUE_WIDTH,
    parameter int TIME_WIDTH  = htpf_pkg::DEF_TIME_WIDTH,
    localparam int DATA_W     = ((TIME_WIDTH + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [DATA_W-1:0]     i_s_tdata,   // sample_time, sample_value
    input  logic                  i_s_tlast,   // curve_last
    input  logic                  i_s_tuser,   // curve_start
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [DATA_W-1:0]     o_m_tdata,   // peak_time, peak_value
    output logic                  o_m_tlast,   // curve_end
    output logic [1:0]            o_m_tuser,   // run_end, status
    // config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW     = htpf_pkg::AMP_WIDTH;
    localparam int CW     = (VALUE_WIDTH + 1 > AW + 1) ? VALUE_WIDTH + 1 : AW + 1;
    localparam int EW     = TIME_WIDTH + VALUE_WIDTH + 3;
    localparam int DEPTH  = htpf_pkg::RQ_DEPTH;
    localparam int PW     = $clog2(DEPTH);
    localparam int NW     = $clog2(DEPTH + 1);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SEARCH = 2'd1;
    localparam logic [1:0] PH_TRACK  = 2'd2;

    // ---------------- config register ----------------
    logic [AW-1:0] r_min_amp;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == htpf_pkg::REG_MIN_AMPLITUDE);
    assign prdata   = (paddr[2] == htpf_pkg::REG_MIN_AMPLITUDE) ? {1'b0, r_min_amp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_amp <= htpf_pkg::AMP_RESET;
        end else if (w_cfg_wr) begin
            r_min_amp <= pwdata[AW-1:0];
        end
    end

    // ---------------- curve state ----------------
    logic [1:0]             r_phase,  n_phase;
    logic                   r_dir_up, n_dir_up;
    logic [TIME_WIDTH-1:0]  r_start_time, n_start_time;
    logic [VALUE_WIDTH-1:0] r_start_value, n_start_value;
    logic [TIME_WIDTH-1:0]  r_ext_time, n_ext_time;
    logic [VALUE_WIDTH-1:0] r_ext_value, n_ext_value;

    logic [NW-1:0] r_count;
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [EW-1:0] r_queue [DEPTH];

    logic                   w_accept, w_pop;
    logic [TIME_WIDTH-1:0]  w_t;
    logic [VALUE_WIDTH-1:0] w_v;
    logic                   w_first, w_last;

    assign w_t      = i_s_tdata[TIME_WIDTH-1:0];
    assign w_v      = i_s_tdata[TIME_WIDTH+VALUE_WIDTH-1:TIME_WIDTH];
    assign w_first  = i_s_tuser;
    assign w_last   = i_s_tlast;
    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_pop    = o_m_tvalid && i_m_tready;

    // differences one bit wider than the value, compared against +/- amplitude
    logic [AW-1:0]        w_amp_eff;
    logic signed [CW-1:0] w_amp, w_namp, w_d, w_e;
    logic                 w_found, w_grow, w_turn;

    assign w_amp_eff = (r_min_amp == '0) ? AW'(1) : r_min_amp;
    assign w_amp     = $signed({{(CW-AW){1'b0}}, w_amp_eff});
    assign w_namp    = -w_amp;
    assign w_d = $signed({{(CW-VALUE_WIDTH){w_v[VALUE_WIDTH-1]}}, w_v})
               - $signed({{(CW-VALUE_WIDTH){r_start_value[VALUE_WIDTH-1]}}, r_start_value});
    assign w_e = $signed({{(CW-VALUE_WIDTH){r_ext_value[VALUE_WIDTH-1]}}, r_ext_value})
               - $signed({{(CW-VALUE_WIDTH){w_v[VALUE_WIDTH-1]}}, w_v});

    assign w_found = (w_d >= w_amp) || (w_d <= w_namp);
    // w_e is extreme minus sample
    assign w_grow  = r_dir_up ? (w_e < 0) : (w_e > 0);
    assign w_turn  = r_dir_up ? (w_e > w_amp) : (w_e < w_namp);

    logic [1:0]        w_push;
    logic [EW-1:0]     w_res0, w_res1;
    htpf_pkg::t_flags  w_fl0, w_fl1;

    always_comb begin
        n_phase       = r_phase;
        n_dir_up      = r_dir_up;
        n_start_time  = r_start_time;
        n_start_value = r_start_value;
        n_ext_time    = r_ext_time;
        n_ext_value   = r_ext_value;
        w_push        = 2'd0;
        w_fl0         = '0;
        w_fl1         = '0;
        w_res0        = '0;
        w_res1        = '0;

        if (w_first) begin
            n_start_time  = w_t;
            n_start_value = w_v;
            if (w_last) begin
                // one-sample curve
                w_fl0   = '{status: 1'b1, curve_end: 1'b1, run_end: 1'b1};
                w_res0  = {w_fl0, w_v, w_t};
                w_push  = 2'd1;
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_SEARCH;
            end
        end else begin
            case (r_phase)
                PH_SEARCH: begin
                    if (w_found) begin
                        n_ext_time  = w_t;
                        n_ext_value = w_v;
                        n_dir_up    = (w_d > 0);
                        w_fl0.run_end = !w_last;
                        w_res0 = {w_fl0, r_start_value, r_start_time};
                        if (w_last) begin
                            w_fl1  = '{status: 1'b0, curve_end: 1'b1, run_end: 1'b1};
                            w_res1 = {w_fl1, w_v, w_t};
                            w_push = 2'd2;
                            n_phase = PH_IDLE;
                        end else begin
                            w_push  = 2'd1;
                            n_phase = PH_TRACK;
                        end
                    end else if (w_last) begin
                        w_fl0   = '{status: 1'b0, curve_end: 1'b1, run_end: 1'b1};
                        w_res0  = {w_fl0, r_start_value, r_start_time};
                        w_push  = 2'd1;
                        n_phase = PH_IDLE;
                    end
                end
                PH_TRACK: begin
                    if (w_grow || w_turn) begin
                        n_ext_time  = w_t;
                        n_ext_value = w_v;
                    end
                    if (!w_grow && w_turn) begin
                        n_dir_up = !r_dir_up;
                    end
                    if (w_last) begin
                        // curve end reports the extreme after this sample
                        w_fl1 = '{status: 1'b0, curve_end: 1'b1, run_end: 1'b1};
                        if (w_grow || w_turn) begin
                            w_res1 = {w_fl1, w_v, w_t};
                        end else begin
                            w_res1 = {w_fl1, r_ext_value, r_ext_time};
                        end
                        n_phase = PH_IDLE;
                    end
                    if (!w_grow && w_turn) begin
                        w_fl0.run_end = !w_last;
                        w_res0 = {w_fl0, r_ext_value, r_ext_time};
                        w_push = w_last ? 2'd2 : 2'd1;
                    end else if (w_last) begin
                        w_res0 = w_res1;
                        w_push = 2'd1;
                    end
                end
                default: begin
                    // idle: samples outside a curve are dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_dir_up <= 1'b0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_dir_up <= n_dir_up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_start_time  <= n_start_time;
            r_start_value <= n_start_value;
            r_ext_time    <= n_ext_time;
            r_ext_value   <= n_ext_value;
        end
    end

    // ---------------- result queue ----------------
    logic [1:0]    w_push_acc;
    logic [PW-1:0] w_wr_ptr1;

    assign w_push_acc = w_accept ? w_push : 2'd0;
    assign w_wr_ptr1  = r_wr_ptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count  <= r_count + NW'(w_push_acc) - NW'(w_pop);
            r_wr_ptr <= r_wr_ptr + PW'(w_push_acc);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_acc != 2'd0) begin
            r_queue[r_wr_ptr] <= w_res0;
        end
        if (w_push_acc == 2'd2) begin
            r_queue[w_wr_ptr1] <= w_res1;
        end
    end

    logic [EW-1:0]    w_head;
    htpf_pkg::t_flags w_head_fl;

    assign w_head     = r_queue[r_rd_ptr];
    assign w_head_fl  = w_head[EW-1:EW-3];
    assign o_s_tready = (r_count <= NW'(DEPTH - 2));
    assign o_m_tvalid = (r_count != '0);
    assign o_m_tdata  = DATA_W'(w_head[TIME_WIDTH+VALUE_WIDTH-1:0]);
    assign o_m_tlast  = w_head_fl.curve_end;
    assign o_m_tuser  = {w_head_fl.status, w_head_fl.run_end};

    // ---------------- checks ----------------
`include "hysteresis_turning_point_finder_macros.svh"

    `HTPF_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= NW'(DEPTH))
    `HTPF_ASSERT_SAME(a_room_on_accept, i_clk, i_rst_n, w_accept, r_count <= NW'(DEPTH - 2))
    `HTPF_ASSERT_SAME(a_status_short, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1], o_m_tlast && o_m_tuser[0])
    `HTPF_ASSERT_SAME(a_curve_end_run_end, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser[0])
    `HTPF_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, w_accept && (w_push != 2'd0), o_m_tvalid)

endmodule

// ----- dv/tb_hysteresis_turning_point_finder.sv -----
// Self-checking testbench for hysteresis_turning_point_finder: directed and random curves,
// with turning points predicted in the bench and compared on the result stream.
// Depends on htpf_pkg and the hysteresis_turning_point_finder RTL.
`timescale 1ns / 1ps

module tb_hysteresis_turning_point_finder;

    localparam logic [2:0] AMP_ADDR = {htpf_pkg::REG_MIN_AMPLITUDE, 2'b00};

    typedef enum logic [1:0] {
        CURVE_IDLE,
        CURVE_SEARCH,
        CURVE_TRACK
    } t_curve_phase;

    typedef struct packed {
        logic [47:0]        stamp;
        logic signed [31:0] level;
        logic               run_end;
        logic               curve_end;
        logic               status;
    } t_peak;

    typedef struct packed {
        logic [47:0] stamp;
        logic [31:0] level;
        logic        opens;
        logic        closes;
        logic        typed;
        t_peak       typed_peak;
    } t_sample_row;

    localparam t_peak NO_PEAK = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;   // sample_time, sample_value
    logic        i_s_tlast;   // curve_last
    logic        i_s_tuser;   // curve_start
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [79:0] o_m_tdata;   // peak_time, peak_value
    logic        o_m_tlast;   // curve_end
    logic [1:0]  o_m_tuser;   // run_end, status
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    hysteresis_turning_point_finder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // bench-side copy of the curve state and threshold
    t_curve_phase       curve_phase = CURVE_IDLE;
    logic               heading_up = 1'b0;
    logic [47:0]        anchor_stamp = '0;
    logic signed [31:0] anchor_level = '0;
    logic [47:0]        hold_stamp = '0;
    logic signed [31:0] hold_level = '0;
    logic [30:0]        amp_copy = htpf_pkg::AMP_RESET;

    t_peak       expected_peaks[$];
    int          mismatch_count = 0;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;
    logic [30:0] phase_amp = htpf_pkg::AMP_RESET;
    logic        typed_valid = 1'b0;
    t_peak       typed_peak = '0;

    t_sample_row directed_rows [21] = '{
        // one-sample curves at the field extremes
        '{48'd0, 32'h8000_0000, 1'b1, 1'b1, 1'b1,
          '{48'd0, 32'h8000_0000, 1'b1, 1'b1, 1'b1}},
        '{48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1,
          '{48'hFFFF_FFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1}},
        // stray sample while idle, dropped
        '{48'd5, 32'h1234_5678, 1'b0, 1'b1, 1'b0, NO_PEAK},
        '{48'd10, 32'h0000_0000, 1'b1, 1'b0, 1'b0, NO_PEAK},
        '{48'd11, 32'h0000_8000, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd12, 32'h0001_0000, 1'b0, 1'b0, 1'b0, NO_PEAK},  // exactly one step away
        '{48'd13, 32'h0003_0000, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd14, 32'h0002_0000, 1'b0, 1'b0, 1'b0, NO_PEAK},  // falls back exactly, no turn
        '{48'd15, 32'h0001_FFFF, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd16, 32'hFFFB_0000, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd17, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd18, 32'h8000_0000, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd19, 32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, NO_PEAK},  // turn on the closing sample
        '{48'd20, 32'h0000_0005, 1'b1, 1'b0, 1'b0, NO_PEAK},
        '{48'd21, 32'h0000_0005, 1'b0, 1'b1, 1'b0, NO_PEAK},  // never left the start
        '{48'd30, 32'h0000_0000, 1'b1, 1'b0, 1'b0, NO_PEAK},
        '{48'd31, 32'h0002_0000, 1'b0, 1'b1, 1'b0, NO_PEAK},  // found on the closing sample
        '{48'd40, 32'h0000_0064, 1'b1, 1'b0, 1'b0, NO_PEAK},
        '{48'd41, 32'h0000_00C8, 1'b1, 1'b0, 1'b0, NO_PEAK},  // restart drops the open curve
        '{48'd42, 32'h0001_00C8, 1'b0, 1'b0, 1'b0, NO_PEAK},
        '{48'd43, 32'h0002_00C8, 1'b0, 1'b1, 1'b0, NO_PEAK}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_expected(input t_peak p);
        expected_peaks.insert(expected_peaks.size(), p);
    endtask

    // Turning points caused by one accepted sample.
    task automatic predict_peaks(input logic [47:0] stamp, input logic signed [31:0] level,
                                 input logic opens, input logic closes,
                                 output t_peak found [2], output int n);
        logic signed [32:0] diff;
        logic signed [32:0] span;
        logic signed [32:0] amp;
        amp = (amp_copy == '0) ? 33'sd1 : $signed({2'b00, amp_copy});
        n = 0;
        if (opens) begin
            anchor_stamp = stamp;
            anchor_level = level;
            if (closes) begin
                found[0] = '{stamp, level, 1'b1, 1'b1, 1'b1};
                n = 1;
                curve_phase = CURVE_IDLE;
            end else begin
                curve_phase = CURVE_SEARCH;
            end
            return;
        end
        case (curve_phase)
            CURVE_SEARCH: begin
                diff = {level[31], level} - {anchor_level[31], anchor_level};
                span = (diff < 0) ? -diff : diff;
                if (span >= amp) begin
                    found[n++] = '{anchor_stamp, anchor_level, 1'b0, 1'b0, 1'b0};
                    hold_stamp = stamp;
                    hold_level = level;
                    heading_up = (diff > 0);
                    curve_phase = CURVE_TRACK;
                end else if (closes) begin
                    found[n++] = '{anchor_stamp, anchor_level, 1'b1, 1'b1, 1'b0};
                    curve_phase = CURVE_IDLE;
                    return;
                end
            end
            CURVE_TRACK: begin
                diff = heading_up ? {hold_level[31], hold_level} - {level[31], level}
                                  : {level[31], level} - {hold_level[31], hold_level};
                if (diff < 0) begin
                    hold_stamp = stamp;
                    hold_level = level;
                end else if (diff > amp) begin
                    found[n++] = '{hold_stamp, hold_level, !closes, 1'b0, 1'b0};
                    hold_stamp = stamp;
                    hold_level = level;
                    heading_up = !heading_up;
                end
            end
            default: return;
        endcase
        if (closes) begin
            found[n++] = '{hold_stamp, hold_level, 1'b1, 1'b1, 1'b0};
            curve_phase = CURVE_IDLE;
        end else if (n > 0) begin
            found[n-1].run_end = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_peak got;
        t_peak want;
        t_peak found [2];
        int    n;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got = '{o_m_tdata[47:0], o_m_tdata[79:48], o_m_tuser[0], o_m_tlast,
                        o_m_tuser[1]};
                if (expected_peaks.size() == 0) begin
                    report_mismatch("result with none pending", got.stamp, 64'd0);
                end else begin
                    want = expected_peaks.pop_front();
                    if (got.stamp !== want.stamp)
                        report_mismatch("peak_time", got.stamp, want.stamp);
                    if (got.level !== want.level)
                        report_mismatch("peak_value", got.level, want.level);
                    if (got.run_end !== want.run_end)
                        report_mismatch("run_end", got.run_end, want.run_end);
                    if (got.curve_end !== want.curve_end)
                        report_mismatch("curve_end", got.curve_end, want.curve_end);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_peaks(i_s_tdata[47:0], i_s_tdata[79:48], i_s_tuser, i_s_tlast,
                              found, n);
                if (typed_valid) begin
                    add_expected(typed_peak);
                end else begin
                    for (int k = 0; k < n; k++) add_expected(found[k]);
                end
            end
            if (psel && penable && pwrite && pready && paddr == AMP_ADDR)
                amp_copy = pwdata[30:0];
        end
    end

    task automatic push_sample(input t_sample_row row);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= {row.level, row.stamp};
        i_s_tuser   <= row.opens;
        i_s_tlast   <= row.closes;
        typed_valid <= row.typed;
        typed_peak  <= row.typed_peak;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_peaks.size() != 0) @(posedge i_clk);
        // an item with no result may still be in flight
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [30:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AMP_ADDR;
        pwdata  <= {1'b0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {1'b0, value}) report_mismatch("min_amplitude readback", prdata, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        phase_amp = value;
    endtask

    // Random walk scaled to the threshold, with some jumps anywhere in range.
    function automatic logic [31:0] next_level(input logic [31:0] prev);
        longint unsigned reach;
        longint          step;
        longint          nxt;
        if ($urandom_range(9) < 2) return $urandom;
        reach = 3 * longint'((phase_amp == '0) ? 31'd1 : phase_amp);
        if (reach > 64'hFFFF_FFFF) reach = 64'hFFFF_FFFF;
        step = longint'($urandom_range(32'(reach), 0));
        nxt = longint'($signed(prev)) + ($urandom_range(1) ? step : -step);
        if (nxt > 64'sh7FFF_FFFF) nxt = 64'sh7FFF_FFFF;
        if (nxt < -64'sh8000_0000) nxt = -64'sh8000_0000;
        return nxt[31:0];
    endfunction

    task automatic run_random_curves(input int quota);
        t_sample_row row;
        logic [63:0] ticks;
        logic [31:0] lvl;
        int          sent;
        int          kind;
        int          len;
        logic        abandon;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(99);
            row = '0;
            if (kind < 7) begin
                // stray sample; dropped unless a curve is open
                row.stamp  = {$urandom, $urandom};
                row.level  = $urandom;
                row.closes = $urandom_range(1);
                push_sample(row);
            end else begin
                ticks   = {$urandom, $urandom};
                lvl     = $urandom;
                len     = (kind < 15) ? 1 : $urandom_range(24, 2);
                abandon = (len > 1) && ($urandom_range(9) == 0);
                for (int k = 0; k < len; k++) begin
                    row.stamp  = ticks[47:0];
                    row.level  = lvl;
                    row.opens  = (k == 0);
                    row.closes = (k == len - 1) && !abandon;
                    push_sample(row);
                    sent++;
                    ticks = ticks + $urandom_range(5000, 1);
                    lvl   = next_level(lvl);
                end
            end
        end
    endtask

    initial begin
        logic [30:0] amp_plan [8];
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        amp_plan = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'd65536,
                     31'($urandom_range(32'hF_FFFF, 1)), 31'($urandom), 31'd16, 31'd3};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) push_sample(directed_rows[i]);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            cfg_write(amp_plan[p]);
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 63; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 63; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            run_random_curves(110);
            wait_drained();
        end

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
